// ===== rtl/euf_pkg.sv =====
// ----------------------------------------------------------------------------
// euf_pkg
// Shared types, constants and fixed-point helpers for the upwind face flux.
// ----------------------------------------------------------------------------
package euf_pkg;

    localparam int WORD_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int HEAT_WIDTH = 18;
    localparam int IO_WIDTH   = 32;
    localparam int UNS_WIDTH  = 31;
    localparam int DIV_LAT    = WORD_WIDTH + 2;

    localparam logic [HEAT_WIDTH-1:0] HEAT_RESET = HEAT_WIDTH'(91750);

    typedef logic signed [WORD_WIDTH-1:0] t_word;
    typedef logic        [WORD_WIDTH-1:0] t_mag;
    typedef logic        [2*WORD_WIDTH-1:0] t_prod;
    typedef logic signed [IO_WIDTH-1:0]   t_io;

    typedef struct packed {
        logic  neg;
        t_prod mag;
    } t_rawp;

    typedef struct packed {
        logic  fault;
        t_word lr;
        t_word lx;
        t_word ly;
        t_word le;
        t_word rr;
        t_word rx;
        t_word ry;
        t_word re;
        t_word sx;
        t_word sy;
    } t_carry;

    localparam longint WMAX_L = (longint'(1) << (WORD_WIDTH - 1)) - 1;
    localparam longint WMIN_L = -WMAX_L - 1;
    localparam longint OMAX_L = (longint'(1) << (IO_WIDTH - 1)) - 1;
    localparam longint OMIN_L = -OMAX_L - 1;
    localparam t_word  WMAX   = t_word'(WMAX_L);
    localparam t_word  WMIN   = t_word'(WMIN_L);
    localparam t_mag   MAG_MAX = {1'b0, {(WORD_WIDTH-1){1'b1}}};
    localparam t_mag   MAG_MIN = {1'b1, {(WORD_WIDTH-1){1'b0}}};

    function automatic t_word clamp_l(input longint v);
        if (v > WMAX_L) begin
            return WMAX;
        end else if (v < WMIN_L) begin
            return WMIN;
        end
        return t_word'(v);
    endfunction

    function automatic t_io out_sat(input t_word a);
        longint v;
        v = longint'(a);
        if (v > OMAX_L) begin
            return t_io'(OMAX_L);
        end else if (v < OMIN_L) begin
            return t_io'(OMIN_L);
        end
        return t_io'(v);
    endfunction

    function automatic t_mag mag(input t_word a);
        return a[WORD_WIDTH-1] ? t_mag'(t_mag'(0) - t_mag'(a)) : t_mag'(a);
    endfunction

    function automatic t_word sat_mag(input logic neg, input t_mag m, input logic ovf);
        if (!neg) begin
            return (ovf || m > MAG_MAX) ? WMAX : t_word'(m);
        end
        return (ovf || m > MAG_MIN) ? WMIN : t_word'(t_mag'(0) - m);
    endfunction

    function automatic t_word sadd(input t_word a, input t_word b);
        logic [WORD_WIDTH:0] s;
        s = {a[WORD_WIDTH-1], a} + {b[WORD_WIDTH-1], b};
        if (s[WORD_WIDTH] != s[WORD_WIDTH-1]) begin
            return s[WORD_WIDTH] ? WMIN : WMAX;
        end
        return t_word'(s[WORD_WIDTH-1:0]);
    endfunction

    function automatic t_word ssub(input t_word a, input t_word b);
        logic [WORD_WIDTH:0] s;
        s = {a[WORD_WIDTH-1], a} - {b[WORD_WIDTH-1], b};
        if (s[WORD_WIDTH] != s[WORD_WIDTH-1]) begin
            return s[WORD_WIDTH] ? WMIN : WMAX;
        end
        return t_word'(s[WORD_WIDTH-1:0]);
    endfunction

    // halve, truncating toward zero
    function automatic t_word half(input t_word a);
        t_word tmp;
        tmp = a + t_word'({{(WORD_WIDTH-1){1'b0}}, a[WORD_WIDTH-1]});
        return tmp >>> 1;
    endfunction

    function automatic t_rawp rawmul(input t_word a, input t_word b);
        t_rawp r;
        r.neg = a[WORD_WIDTH-1] ^ b[WORD_WIDTH-1];
        r.mag = t_prod'(mag(a)) * t_prod'(mag(b));
        return r;
    endfunction

    function automatic t_word fin(input t_rawp x);
        t_prod sh;
        sh = x.mag >> FRAC_BITS;
        return sat_mag(x.neg, sh[WORD_WIDTH-1:0], |sh[2*WORD_WIDTH-1:WORD_WIDTH]);
    endfunction

endpackage

// ===== rtl/euler_upwind_face_flux.sv =====
// ----------------------------------------------------------------------------
// euler_upwind_face_flux
// Upwind face flux for the 2D compressible Euler equations, Q16.16 fixed point.
// ----------------------------------------------------------------------------
// Accepts one face every cycle unless the output stalls, and returns its flux
// after 3 input and square stages, the six parallel bit-per-stage dividers that
// form the velocities and kinetic terms, and 6 stages of pressure, normal
// velocity and flux products. A stall at the output freezes the whole pipeline;
// o_stall follows i_stall while a result is waiting.
// Zero density on either side or a zero face vector gives fault and zero flux.
module euler_upwind_face_flux (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [euf_pkg::HEAT_WIDTH-1:0]      i_cfg_wdata,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [euf_pkg::UNS_WIDTH-1:0]       i_left_density,
    input  logic signed [euf_pkg::IO_WIDTH-1:0] i_left_mom_x,
    input  logic signed [euf_pkg::IO_WIDTH-1:0] i_left_mom_y,
    input  logic [euf_pkg::UNS_WIDTH-1:0]       i_left_energy,
    input  logic [euf_pkg::UNS_WIDTH-1:0]       i_right_density,
    input  logic signed [euf_pkg::IO_WIDTH-1:0] i_right_mom_x,
    input  logic signed [euf_pkg::IO_WIDTH-1:0] i_right_mom_y,
    input  logic [euf_pkg::UNS_WIDTH-1:0]       i_right_energy,
    input  logic signed [euf_pkg::IO_WIDTH-1:0] i_face_x,
    input  logic signed [euf_pkg::IO_WIDTH-1:0] i_face_y,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [euf_pkg::IO_WIDTH-1:0] o_flux_mass,
    output logic signed [euf_pkg::IO_WIDTH-1:0] o_flux_mom_x,
    output logic signed [euf_pkg::IO_WIDTH-1:0] o_flux_mom_y,
    output logic signed [euf_pkg::IO_WIDTH-1:0] o_flux_energy,
    output logic                                o_fault
);

    localparam int W = euf_pkg::WORD_WIDTH;
    localparam int F = euf_pkg::FRAC_BITS;
    localparam int L = euf_pkg::DIV_LAT;

    logic en;
    logic [euf_pkg::HEAT_WIDTH-1:0] r_heat;
    euf_pkg::t_word gm1;

    // valid bits
    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_v7, r_v8, r_out_v;
    logic r_vl [0:L-1];

    // payload
    euf_pkg::t_carry r_c1, r_c2, r_c3, r_c4, r_c5, r_c6, r_c7, r_c8;
    euf_pkg::t_carry r_cl [0:L-1];
    euf_pkg::t_carry n_c1;
    euf_pkg::t_rawp  r_lxx, r_lyy, r_rxx, r_ryy;
    euf_pkg::t_word  r_kel, r_ker;
    euf_pkg::t_word  d_vlx, d_vly, d_vrx, d_vry, d_tl, d_tr;
    euf_pkg::t_word  r_ux, r_uy, r_el, r_er;
    euf_pkg::t_rawp  r_pml, r_pmr, r_qmx, r_qmy;
    euf_pkg::t_word  r_pl, r_pr, r_qx, r_qy;
    euf_pkg::t_word  r_p, r_q;
    euf_pkg::t_rawp  r_m0, r_m1, r_m2, r_m3, r_psx, r_psy, r_pq;
    euf_pkg::t_word  n_s0, n_s1, n_s2, n_s3;
    euf_pkg::t_io    r_f0, r_f1, r_f2, r_f3;
    logic            r_fault;

    assign en      = !r_out_v || !i_stall;
    assign o_stall = !en;
    assign gm1     = euf_pkg::clamp_l(longint'(r_heat) - (longint'(1) << F));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heat <= euf_pkg::HEAT_RESET;
        end else if (i_cfg_we) begin
            r_heat <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0; r_v2 <= 1'b0; r_v3 <= 1'b0; r_v4 <= 1'b0;
            r_v5 <= 1'b0; r_v6 <= 1'b0; r_v7 <= 1'b0; r_v8 <= 1'b0;
            r_out_v <= 1'b0;
            for (int k = 0; k < L; k++) begin
                r_vl[k] <= 1'b0;
            end
        end else if (en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_vl[0] <= r_v3;
            for (int k = 1; k < L; k++) begin
                r_vl[k] <= r_vl[k-1];
            end
            r_v4 <= r_vl[L-1];
            r_v5 <= r_v4;
            r_v6 <= r_v5;
            r_v7 <= r_v6;
            r_v8 <= r_v7;
            r_out_v <= r_v8;
        end
    end

    // stage 1: clamp to the word, fault check
    always_comb begin
        n_c1.lr = euf_pkg::clamp_l(longint'(i_left_density));
        n_c1.lx = euf_pkg::clamp_l(longint'(i_left_mom_x));
        n_c1.ly = euf_pkg::clamp_l(longint'(i_left_mom_y));
        n_c1.le = euf_pkg::clamp_l(longint'(i_left_energy));
        n_c1.rr = euf_pkg::clamp_l(longint'(i_right_density));
        n_c1.rx = euf_pkg::clamp_l(longint'(i_right_mom_x));
        n_c1.ry = euf_pkg::clamp_l(longint'(i_right_mom_y));
        n_c1.re = euf_pkg::clamp_l(longint'(i_right_energy));
        n_c1.sx = euf_pkg::clamp_l(longint'(i_face_x));
        n_c1.sy = euf_pkg::clamp_l(longint'(i_face_y));
        n_c1.fault = (n_c1.lr == '0) || (n_c1.rr == '0) ||
                     ((n_c1.sx == '0) && (n_c1.sy == '0));
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c1 <= n_c1;
            // stage 2: squares of momenta
            r_c2  <= r_c1;
            r_lxx <= euf_pkg::rawmul(r_c1.lx, r_c1.lx);
            r_lyy <= euf_pkg::rawmul(r_c1.ly, r_c1.ly);
            r_rxx <= euf_pkg::rawmul(r_c1.rx, r_c1.rx);
            r_ryy <= euf_pkg::rawmul(r_c1.ry, r_c1.ry);
            // stage 3: half of twice the kinetic energy times density
            r_c3  <= r_c2;
            r_kel <= euf_pkg::half(euf_pkg::sadd(euf_pkg::fin(r_lxx), euf_pkg::fin(r_lyy)));
            r_ker <= euf_pkg::half(euf_pkg::sadd(euf_pkg::fin(r_rxx), euf_pkg::fin(r_ryy)));
            // delay line beside the dividers
            r_cl[0] <= r_c3;
            for (int k = 1; k < L; k++) begin
                r_cl[k] <= r_cl[k-1];
            end
            // stage 4: velocities and internal energies
            r_c4 <= r_cl[L-1];
            r_ux <= euf_pkg::half(euf_pkg::sadd(d_vlx, d_vrx));
            r_uy <= euf_pkg::half(euf_pkg::sadd(d_vly, d_vry));
            r_el <= euf_pkg::ssub(r_cl[L-1].le, d_tl);
            r_er <= euf_pkg::ssub(r_cl[L-1].re, d_tr);
            // stage 5: pressure and normal velocity products
            r_c5  <= r_c4;
            r_pml <= euf_pkg::rawmul(gm1, r_el);
            r_pmr <= euf_pkg::rawmul(gm1, r_er);
            r_qmx <= euf_pkg::rawmul(r_ux, r_c4.sx);
            r_qmy <= euf_pkg::rawmul(r_uy, r_c4.sy);
            // stage 6
            r_c6 <= r_c5;
            r_pl <= euf_pkg::fin(r_pml);
            r_pr <= euf_pkg::fin(r_pmr);
            r_qx <= euf_pkg::fin(r_qmx);
            r_qy <= euf_pkg::fin(r_qmy);
            // stage 7: mean pressure, q = u . face
            r_c7 <= r_c6;
            r_p  <= euf_pkg::half(euf_pkg::sadd(r_pl, r_pr));
            r_q  <= euf_pkg::sadd(r_qx, r_qy);
            // stage 8: upwind state times q, pressure terms
            r_c8 <= r_c7;
            if (!r_q[W-1]) begin
                r_m0 <= euf_pkg::rawmul(r_c7.lr, r_q);
                r_m1 <= euf_pkg::rawmul(r_c7.lx, r_q);
                r_m2 <= euf_pkg::rawmul(r_c7.ly, r_q);
                r_m3 <= euf_pkg::rawmul(r_c7.le, r_q);
            end else begin
                r_m0 <= euf_pkg::rawmul(r_c7.rr, r_q);
                r_m1 <= euf_pkg::rawmul(r_c7.rx, r_q);
                r_m2 <= euf_pkg::rawmul(r_c7.ry, r_q);
                r_m3 <= euf_pkg::rawmul(r_c7.re, r_q);
            end
            r_psx <= euf_pkg::rawmul(r_p, r_c7.sx);
            r_psy <= euf_pkg::rawmul(r_p, r_c7.sy);
            r_pq  <= euf_pkg::rawmul(r_p, r_q);
            // stage 9: output register
            r_fault <= r_c8.fault;
            r_f0 <= r_c8.fault ? '0 : euf_pkg::out_sat(n_s0);
            r_f1 <= r_c8.fault ? '0 : euf_pkg::out_sat(n_s1);
            r_f2 <= r_c8.fault ? '0 : euf_pkg::out_sat(n_s2);
            r_f3 <= r_c8.fault ? '0 : euf_pkg::out_sat(n_s3);
        end
    end

    always_comb begin
        n_s0 = euf_pkg::fin(r_m0);
        n_s1 = euf_pkg::sadd(euf_pkg::fin(r_m1), euf_pkg::fin(r_psx));
        n_s2 = euf_pkg::sadd(euf_pkg::fin(r_m2), euf_pkg::fin(r_psy));
        n_s3 = euf_pkg::sadd(euf_pkg::fin(r_m3), euf_pkg::fin(r_pq));
    end

    euf_div u_div_lx (.i_clk(i_clk), .i_en(en), .i_num(r_c3.lx), .i_den(r_c3.lr), .o_quo(d_vlx));
    euf_div u_div_ly (.i_clk(i_clk), .i_en(en), .i_num(r_c3.ly), .i_den(r_c3.lr), .o_quo(d_vly));
    euf_div u_div_rx (.i_clk(i_clk), .i_en(en), .i_num(r_c3.rx), .i_den(r_c3.rr), .o_quo(d_vrx));
    euf_div u_div_ry (.i_clk(i_clk), .i_en(en), .i_num(r_c3.ry), .i_den(r_c3.rr), .o_quo(d_vry));
    euf_div u_div_tl (.i_clk(i_clk), .i_en(en), .i_num(r_kel),   .i_den(r_c3.lr), .o_quo(d_tl));
    euf_div u_div_tr (.i_clk(i_clk), .i_en(en), .i_num(r_ker),   .i_den(r_c3.rr), .o_quo(d_tr));

    assign o_valid       = r_out_v;
    assign o_fault       = r_fault;
    assign o_flux_mass   = r_f0;
    assign o_flux_mom_x  = r_f1;
    assign o_flux_mom_y  = r_f2;
    assign o_flux_energy = r_f3;

    a_fault_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_fault) |-> (o_flux_mass == '0 && o_flux_mom_x == '0 &&
                                  o_flux_mom_y == '0 && o_flux_energy == '0))
        else $error("fault item carries nonzero flux");

    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with no waiting item");

    a_stall_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |-> o_stall)
        else $error("pipeline advanced under output stall");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_v1)
        else $error("accepted item lost at entry");

endmodule

// ===== rtl/euf_div.sv =====
// ----------------------------------------------------------------------------
// euf_div
// Pipelined restoring divider: (num << FRAC_BITS) / den, one quotient bit per
// stage, truncated toward zero and saturated to the word. Zero divisor gives 0.
// ----------------------------------------------------------------------------
module euf_div (
    input  logic          i_clk,
    input  logic          i_en,
    input  euf_pkg::t_word i_num,
    input  euf_pkg::t_word i_den,
    output euf_pkg::t_word o_quo
);

    localparam int W = euf_pkg::WORD_WIDTH;
    localparam int F = euf_pkg::FRAC_BITS;

    euf_pkg::t_mag  r_rem [0:W];
    euf_pkg::t_mag  r_num [0:W];
    euf_pkg::t_mag  r_quo [0:W];
    euf_pkg::t_mag  r_den [0:W];
    logic           r_neg [0:W];
    logic           r_ovf [0:W];
    logic           r_dz  [0:W];
    euf_pkg::t_word r_out;

    euf_pkg::t_mag n_mnum;
    euf_pkg::t_mag n_mden;

    assign n_mnum = euf_pkg::mag(i_num);
    assign n_mden = euf_pkg::mag(i_den);

    // quotient bits at or above W only mean overflow
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= n_mnum >> (W - F);
            r_num[0] <= n_mnum << F;
            r_quo[0] <= '0;
            r_den[0] <= n_mden;
            r_neg[0] <= i_num[W-1] ^ i_den[W-1];
            r_ovf[0] <= (n_mnum >> (W - F)) >= n_mden;
            r_dz[0]  <= (n_mden == '0);
        end
    end

    for (genvar k = 0; k < W; k++) begin : g_step
        logic [W:0]    n_trial;
        logic          n_ge;
        euf_pkg::t_mag n_rem;

        always_comb begin
            n_trial = {r_rem[k], r_num[k][W-1]};
            n_ge    = n_trial >= {1'b0, r_den[k]};
            n_rem   = n_ge ? W'(n_trial - {1'b0, r_den[k]}) : n_trial[W-1:0];
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1] <= n_rem;
                r_num[k+1] <= r_num[k] << 1;
                r_quo[k+1] <= {r_quo[k][W-2:0], n_ge};
                r_den[k+1] <= r_den[k];
                r_neg[k+1] <= r_neg[k];
                r_ovf[k+1] <= r_ovf[k];
                r_dz[k+1]  <= r_dz[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out <= r_dz[W] ? '0 : euf_pkg::sat_mag(r_neg[W], r_quo[W], r_ovf[W]);
        end
    end

    assign o_quo = r_out;

endmodule

// ===== test/euler_upwind_face_flux_test.sv =====
// ----------------------------------------------------------------------------
// euler_upwind_face_flux_test
// Streams face states through the flux unit under random input gaps and
// output stalls, predicts each flux in Q16.16 and compares field by field.
// ----------------------------------------------------------------------------
module euler_upwind_face_flux_test;

    localparam longint WORD_HI = 64'sd2147483647;
    localparam longint WORD_LO = -64'sd2147483648;
    localparam longint ONE_Q   = 64'sd65536;
    localparam int     DRAIN   = 60;
    localparam int     WD_MAX  = 4000;

    typedef logic [euf_pkg::UNS_WIDTH-1:0]       t_uns;
    typedef logic signed [euf_pkg::IO_WIDTH-1:0] t_sio;

    typedef struct {
        t_uns lr, le, rr, re;
        t_sio lx, ly, rx, ry, sx, sy;
    } t_face;

    typedef struct {
        t_sio mass, mx, my, en;
        logic fault;
    } t_flux;

    logic i_clk, i_rst_n, i_cfg_we, i_valid, i_stall;
    logic [euf_pkg::HEAT_WIDTH-1:0] i_cfg_wdata;
    logic o_stall, o_valid, o_fault;
    t_sio o_flux_mass, o_flux_mom_x, o_flux_mom_y, o_flux_energy;
    t_face cur;

    t_face pending[$];
    t_flux flux_due[$];
    longint heat;
    int gap_in, gap_out, idle_cycles;
    bit quiet, failed;

    euler_upwind_face_flux uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_left_density(cur.lr), .i_left_mom_x(cur.lx), .i_left_mom_y(cur.ly),
        .i_left_energy(cur.le), .i_right_density(cur.rr), .i_right_mom_x(cur.rx),
        .i_right_mom_y(cur.ry), .i_right_energy(cur.re),
        .i_face_x(cur.sx), .i_face_y(cur.sy),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_flux_mass(o_flux_mass), .o_flux_mom_x(o_flux_mom_x),
        .o_flux_mom_y(o_flux_mom_y), .o_flux_energy(o_flux_energy), .o_fault(o_fault)
    );

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic longint wclamp(longint v);
        if (v > WORD_HI) return WORD_HI;
        if (v < WORD_LO) return WORD_LO;
        return v;
    endfunction

    function automatic longint signed_from_mag(bit neg, longint unsigned m);
        if (!neg) return (m > longint'(WORD_HI)) ? WORD_HI : longint'(m);
        return (m > longint'(WORD_HI) + 1) ? WORD_LO : -longint'(m);
    endfunction

    function automatic longint unsigned absval(longint v);
        return v < 0 ? longint'(-v) : longint'(v);
    endfunction

    function automatic longint qmul(longint a, longint b);
        longint unsigned p;
        p = (absval(a) * absval(b)) >> euf_pkg::FRAC_BITS;
        return signed_from_mag((a < 0) != (b < 0), p);
    endfunction

    function automatic longint qdiv(longint a, longint b);
        if (b == 0) return 0;
        return signed_from_mag((a < 0) != (b < 0),
                               (absval(a) << euf_pkg::FRAC_BITS) / absval(b));
    endfunction

    function automatic longint pressure(longint gm1, longint rho, longint mx, longint my,
                                        longint e);
        longint ke2;
        ke2 = wclamp(qmul(mx, mx) + qmul(my, my));
        return qmul(gm1, wclamp(e - qdiv(ke2 / 2, rho)));
    endfunction

    function automatic t_flux face_flux(t_face f, longint hr);
        t_flux r;
        longint gm1, ux, uy, p, q, d, x, y, e;
        r = '{default: '0};
        if (f.lr == 0 || f.rr == 0 || (f.sx == 0 && f.sy == 0)) begin
            r.fault = 1'b1;
            return r;
        end
        gm1 = wclamp(hr - ONE_Q);
        ux = wclamp(qdiv(f.lx, f.lr) + qdiv(f.rx, f.rr)) / 2;
        uy = wclamp(qdiv(f.ly, f.lr) + qdiv(f.ry, f.rr)) / 2;
        p = wclamp(pressure(gm1, f.lr, f.lx, f.ly, f.le)
                   + pressure(gm1, f.rr, f.rx, f.ry, f.re)) / 2;
        q = wclamp(qmul(ux, f.sx) + qmul(uy, f.sy));
        if (q >= 0) begin
            d = f.lr; x = f.lx; y = f.ly; e = f.le;
        end else begin
            d = f.rr; x = f.rx; y = f.ry; e = f.re;
        end
        r.mass = t_sio'(qmul(d, q));
        r.mx = t_sio'(wclamp(qmul(x, q) + qmul(p, f.sx)));
        r.my = t_sio'(wclamp(qmul(y, q) + qmul(p, f.sy)));
        r.en = t_sio'(wclamp(qmul(e, q) + qmul(p, q)));
        return r;
    endfunction

    function automatic logic signed [31:0] rnd_s(int span);
        return $signed($urandom_range(2 * span, 0)) - span;
    endfunction

    function automatic t_face rand_face();
        t_face f;
        int mode;
        mode = $urandom_range(99);
        f.lr = t_uns'($urandom); f.le = t_uns'($urandom);
        f.rr = t_uns'($urandom); f.re = t_uns'($urandom);
        f.lx = $urandom; f.ly = $urandom; f.rx = $urandom; f.ry = $urandom;
        f.sx = $urandom; f.sy = $urandom;
        if (mode < 70) begin
            f.lr = t_uns'($urandom_range(1 << 21, 1 << 12));
            f.rr = t_uns'($urandom_range(1 << 21, 1 << 12));
            f.le = t_uns'($urandom_range(1 << 23));
            f.re = t_uns'($urandom_range(1 << 23));
            f.lx = rnd_s(1 << 20); f.ly = rnd_s(1 << 20);
            f.rx = rnd_s(1 << 20); f.ry = rnd_s(1 << 20);
            f.sx = rnd_s(1 << 18); f.sy = rnd_s(1 << 18);
        end
        if (mode >= 70 && mode < 74) f.lr = 0;
        if (mode >= 74 && mode < 78) f.rr = 0;
        if (mode >= 78 && mode < 82) begin
            f.sx = 0; f.sy = 0;
        end
        if (mode >= 82 && mode < 86) f.sx = 0;
        if (mode >= 86 && mode < 90) begin
            f.lx = 0; f.ly = 0; f.rx = 0; f.ry = 0;
        end
        return f;
    endfunction

    task automatic add_face(logic [30:0] lr, logic signed [31:0] lx, logic signed [31:0] ly,
                            logic [30:0] le, logic [30:0] rr, logic signed [31:0] rx,
                            logic signed [31:0] ry, logic [30:0] re,
                            logic signed [31:0] sx, logic signed [31:0] sy);
        t_face f;
        f.lr = lr; f.lx = lx; f.ly = ly; f.le = le;
        f.rr = rr; f.rx = rx; f.ry = ry; f.re = re; f.sx = sx; f.sy = sy;
        pending.push_back(f);
    endtask

    task automatic drain();
        while (pending.size() != 0 || flux_due.size() != 0 || i_valid) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic set_heat(logic [euf_pkg::HEAT_WIDTH-1:0] v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        heat = v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic check_field(string name, logic signed [31:0] want, logic signed [31:0] got);
        if (want !== got) begin
            $display("%0t mismatch %s: expected %0d actual %0d", $time, name, want, got);
            failed = 1;
        end
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                flux_due.push_back(face_flux(cur, heat));
            end
            if (!i_valid || !o_stall) begin
                if (gap_in > 0) begin
                    gap_in <= gap_in - 1;
                    i_valid <= 1'b0;
                end else if (!quiet && $urandom_range(7) == 0) begin
                    gap_in <= $urandom_range(6);
                    i_valid <= 1'b0;
                end else if (pending.size() != 0) begin
                    cur <= pending.pop_front();
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_flux want;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (flux_due.size() == 0) begin
                    $display("%0t unexpected item: expected none actual %0d %0d %0d %0d %0b",
                             $time, o_flux_mass, o_flux_mom_x, o_flux_mom_y,
                             o_flux_energy, o_fault);
                    failed = 1;
                end else begin
                    want = flux_due.pop_front();
                    check_field("flux_mass", want.mass, o_flux_mass);
                    check_field("flux_mom_x", want.mx, o_flux_mom_x);
                    check_field("flux_mom_y", want.my, o_flux_mom_y);
                    check_field("flux_energy", want.en, o_flux_energy);
                    check_field("fault", 32'(want.fault), 32'(o_fault));
                end
            end
            if (gap_out > 0) begin
                gap_out <= gap_out - 1;
                i_stall <= 1'b1;
            end else if (!quiet && $urandom_range(7) == 0) begin
                gap_out <= $urandom_range(6);
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WD_MAX) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        logic [euf_pkg::HEAT_WIDTH-1:0] heats[5];
        heats = '{18'd65536, 18'd131072, 18'd0, 18'h3FFFF, 18'd91750};
        i_rst_n = 0; i_cfg_we = 0; i_cfg_wdata = '0; i_valid = 0; i_stall = 0;
        cur = '{default: '0};
        gap_in = 0; gap_out = 0; idle_cycles = 0; quiet = 0; failed = 0;
        heat = euf_pkg::HEAT_RESET;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        add_face('1, '1, '1, '1, '1, '1, '1, '1, '1, '1);
        add_face('1, 32'sh7FFFFFFF, 32'sh7FFFFFFF, '1, '1, 32'sh80000000, 32'sh80000000,
                 '1, 32'sh7FFFFFFF, 32'sh80000000);
        add_face(1, 32'sh80000000, 32'sh7FFFFFFF, 0, 1, 32'sh80000000, 32'sh80000000,
                 0, 32'sh80000000, 32'sh7FFFFFFF);
        add_face(0, 65536, 0, 65536, 65536, 65536, 0, 65536, 65536, 0);
        add_face(65536, 65536, 0, 65536, 0, 65536, 0, 65536, 65536, 0);
        add_face(65536, 65536, 0, 65536, 65536, 65536, 0, 65536, 0, 0);
        add_face(65536, 0, 0, 163840, 131072, 0, 0, 327680, 65536, 0);
        add_face(65536, 65536, 0, 0, 65536, 65536, 0, 0, 0, 65536);
        add_face(65536, -65536, 32768, 200000, 131072, -131072, 0, 300000, 65536, 65536);
        add_face(65536, 1, 0, 100000, 65536, 1, 0, 100000, 1, 0);
        add_face(131072, 98304, -65536, 500000, 65536, -98304, 65536, 400000, -65536, 32768);
        add_face(1, 1, 1, 1, 1, 1, 1, 1, 1, 1);
        add_face(65536, 0, 0, '1, 65536, 0, 0, '1, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
        repeat (250) pending.push_back(rand_face());
        drain();

        foreach (heats[k]) begin
            set_heat(heats[k]);
            if (k == 4) quiet = 1;
            add_face(65536, 65536, 0, 200000, 65536, 0, 65536, 200000, 65536, 65536);
            repeat (250) pending.push_back(rand_face());
            drain();
        end

        if (!failed) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

// ===== euler_upwind_face_flux.f =====
rtl/euf_pkg.sv
rtl/euf_div.sv
rtl/euler_upwind_face_flux.sv
test/euler_upwind_face_flux_test.sv
